// ----- design/max_priority_queue_unit_macros.svh -----
// ----------------------------------------------------------------------------
// max_priority_queue_unit assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MAX_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication.
`define MPQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MPQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mpq_pkg
// Types, field widths and operation/status codes of the priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int MPQ_DEPTH = 16;

    localparam int FUNC_W   = 2;
    localparam int PRIO_W   = 16;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

    // per-cell control: load a new entry, or take the neighbor's entry
    typedef struct packed {
        logic load;
        logic advance;
    } cell_ctrl_t;

endpackage

// ----- design/mpq_cell.sv -----
// ----------------------------------------------------------------------------
// mpq_cell
// One queue slot: holds an entry, loads a new one or takes its neighbor's.
// ----------------------------------------------------------------------------
module mpq_cell (
    input  logic                clk,
    input  mpq_pkg::cell_ctrl_t ctrl,
    input  mpq_pkg::entry_t     new_entry,
    input  mpq_pkg::entry_t     next_entry,
    output mpq_pkg::entry_t     entry
);
    import mpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.advance)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- design/max_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// max_priority_queue_unit
// Bounded max-first priority queue, oldest entry wins ties, on a ring of cells.
// ----------------------------------------------------------------------------
// Sequence: insert, full, empty and unused codes go from idle straight to the finish
//   state; peek scans the ring first, remove scans and then closes the gap in a shift state.
// Throughput: one operation at a time; the next is taken once the result is
//   registered. Peek/remove time is set by one full rotation of the DEPTH-cell ring.
// Reset: entry count and control cleared at once; cell contents are not reset
//   and are only read at positions below the count.
`include "max_priority_queue_unit_macros.svh"

module max_priority_queue_unit #(
    parameter int DEPTH = mpq_pkg::MPQ_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic        [mpq_pkg::FUNC_W-1:0]     func,
    input  logic signed [mpq_pkg::PRIO_W-1:0]     priority_req,
    input  logic signed [mpq_pkg::DATA_W-1:0]     payload,
    // response channel
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic        [mpq_pkg::STATUS_W-1:0]   status,
    output logic signed [mpq_pkg::PRIO_W-1:0]     out_priority,
    output logic signed [mpq_pkg::DATA_W-1:0]     out_payload,
    output logic        [mpq_pkg::COUNT_W-1:0]    count
);
    import mpq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t                   state_reg;
    logic [CW-1:0]            count_reg;
    logic [IW-1:0]            step_reg;
    logic [IW-1:0]            best_idx_reg;
    entry_t                   best_reg;
    logic [FUNC_W-1:0]        op_reg;
    logic [STATUS_W-1:0]      res_status_reg;

    logic                     rsp_valid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic signed [PRIO_W-1:0] out_priority_reg;
    logic signed [DATA_W-1:0] out_payload_reg;
    logic [COUNT_W-1:0]       count_out_reg;

    logic                     req_fire;
    logic                     slot_free;
    logic                     rsp_load;
    logic                     do_insert;
    entry_t                   req_entry;
    entry_t                   cell_q [DEPTH];
    cell_ctrl_t               cell_ctrl [DEPTH];
    entry_t                   head;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_load  = (state_reg == S_FINISH) && slot_free;
    assign do_insert = req_fire && (func == FUNC_INSERT) && (count_reg < CW'(DEPTH));

    assign req_entry.prio = priority_req;
    assign req_entry.data = payload;

    // Cell 0 is the head of the ring; during a scan every cell takes the entry
    // of the cell above it, so the head sees positions 0..DEPTH-1 in order and
    // the ring is back in place after one full rotation. A remove then closes the
    // gap in one step: every cell at or above the winner takes its neighbor.
    assign head = cell_q[0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % DEPTH;

        assign cell_ctrl[i].load    = do_insert && (count_reg == CW'(i));
        assign cell_ctrl[i].advance = (state_reg == S_SCAN) ||
                                      ((state_reg == S_SHIFT) && (IW'(i) >= best_idx_reg));

        mpq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .new_entry  (req_entry),
            .next_entry (cell_q[NXT]),
            .entry      (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces one leaving in the same cycle
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        op_reg       <= func;
                        step_reg     <= '0;
                        best_idx_reg <= '0;
                        best_reg     <= '0;
                        if (func == FUNC_INSERT)
                        begin
                            state_reg <= S_FINISH;
                            if (do_insert)
                            begin
                                count_reg      <= count_reg + CW'(1);
                                res_status_reg <= ST_OK;
                            end
                            else
                            begin
                                res_status_reg <= ST_FULL;
                            end
                        end
                        else if ((func == FUNC_PEEK) || (func == FUNC_REMOVE))
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_reg <= ST_EMPTY;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                res_status_reg <= ST_OK;
                                state_reg      <= S_SCAN;
                            end
                        end
                        else
                        begin
                            res_status_reg <= ST_OK;
                            state_reg      <= S_FINISH;
                        end
                    end
                end

                S_SCAN:
                begin
                    // strict compare keeps the oldest of equal priorities
                    if (CW'(step_reg) < count_reg)
                    begin
                        if ((step_reg == '0) || (head.prio > best_reg.prio))
                        begin
                            best_reg     <= head;
                            best_idx_reg <= step_reg;
                        end
                    end
                    step_reg <= step_reg + IW'(1);
                    if (step_reg == IW'(DEPTH - 1))
                    begin
                        state_reg <= (op_reg == FUNC_REMOVE) ? S_SHIFT : S_FINISH;
                    end
                end

                S_SHIFT:
                begin
                    count_reg <= count_reg - CW'(1);
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        status_reg       <= res_status_reg;
                        out_priority_reg <= best_reg.prio;
                        out_payload_reg  <= best_reg.data;
                        count_out_reg    <= COUNT_W'(count_reg);
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign out_priority = out_priority_reg;
    assign out_payload  = out_payload_reg;
    assign count        = count_out_reg;

    `MPQ_ASSERT_NXT(a_insert_counts, do_insert, count_reg == $past(count_reg) + CW'(1), "insert did not raise the count")
    `MPQ_ASSERT_NXT(a_remove_counts, state_reg == S_SHIFT, count_reg == $past(count_reg) - CW'(1), "remove did not lower the count")
    `MPQ_ASSERT_IMP(a_shift_in_range, state_reg == S_SHIFT, CW'(best_idx_reg) < count_reg, "removed position beyond the count")
    `MPQ_ASSERT_NXT(a_scan_ends, (state_reg == S_SCAN) && (step_reg == IW'(DEPTH - 1)), state_reg != S_SCAN, "scan ran past one rotation")
    `MPQ_ASSERT_IMP(a_count_bound, rsp_valid_reg, count_reg <= CW'(DEPTH), "count beyond depth")

endmodule
